// ===== src/aero_stability_moment_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the stability moment unit
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef AERO_STABILITY_MOMENT_UNIT_ASSERT_SVH
`define AERO_STABILITY_MOMENT_UNIT_ASSERT_SVH

// same-cycle implication
`define ASMU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("asmu check failed");

// next-cycle implication
`define ASMU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("asmu check failed");

`endif

// ===== src/asmu_pkg.sv =====
// ---------------------------------------------------------------------------
// asmu_pkg
// Shared constants, register codes and pipeline types.
// ---------------------------------------------------------------------------
`default_nettype none
package asmu_pkg;

  localparam int DIV_BITS    = 48;               // dividend width = quotient width
  localparam int LANE_LAT    = DIV_BITS + 9;     // lane stages, S0 output to moment
  localparam int QM_TAP      = DIV_BITS + 4;     // common stage aligned to multiply entry
  localparam int ANGLE_LIMIT = 4096;             // 0.5 rad in Q2.13

  typedef enum logic [2:0] {
    CFG_MIN_AIRSPEED  = 3'd0,
    CFG_PITCH_STAB    = 3'd1,
    CFG_YAW_STAB      = 3'd2,
    CFG_ROLL_STAB     = 3'd3,
    CFG_PITCH_DAMP    = 3'd4,
    CFG_YAW_DAMP      = 3'd5,
    CFG_ROLL_DAMP     = 3'd6,
    CFG_MOMENT_FACTOR = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic        vld;
    logic        gate;
    logic [31:0] tq_p;
    logic [31:0] tq_y;
    logic [31:0] tq_r;
    logic [51:0] qm;
  } common_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] stab;
  } div_side_t;

  typedef struct packed {
    logic        neg;
    logic [33:0] mag;
  } moment_t;

  typedef struct packed {
    logic [31:0] tq_p;
    logic [31:0] tq_y;
    logic [31:0] tq_r;
    logic        applied;
    logic        sat;
  } res_t;

endpackage
`default_nettype wire

// ===== src/asmu_if.sv =====
// ---------------------------------------------------------------------------
// asmu channel interfaces
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
`default_nettype none
interface asmu_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        air_speed;
  logic signed [16:0] forward_speed;
  logic signed [15:0] attack_angle;
  logic signed [15:0] slip_angle;
  logic [19:0]        dyn_pressure;
  logic signed [15:0] rate_pitch;
  logic signed [15:0] rate_yaw;
  logic signed [15:0] rate_roll;
  logic signed [31:0] torque_in_pitch;
  logic signed [31:0] torque_in_yaw;
  logic signed [31:0] torque_in_roll;

  modport source (output valid, air_speed, forward_speed, attack_angle, slip_angle,
                  dyn_pressure, rate_pitch, rate_yaw, rate_roll, torque_in_pitch,
                  torque_in_yaw, torque_in_roll, input ready);
  modport sink (input valid, air_speed, forward_speed, attack_angle, slip_angle,
                dyn_pressure, rate_pitch, rate_yaw, rate_roll, torque_in_pitch,
                torque_in_yaw, torque_in_roll, output ready);
endinterface

interface asmu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] torque_out_pitch;
  logic signed [31:0] torque_out_yaw;
  logic signed [31:0] torque_out_roll;
  logic               moments_applied;
  logic               saturated;

  modport source (output valid, torque_out_pitch, torque_out_yaw, torque_out_roll,
                  moments_applied, saturated, input ready);
  modport sink (input valid, torque_out_pitch, torque_out_yaw, torque_out_roll,
                moments_applied, saturated, output ready);
endinterface
`default_nettype wire

// ===== src/asmu_div.sv =====
// ---------------------------------------------------------------------------
// asmu_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module asmu_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [15:0]                d_in,
  input  wire logic [asmu_pkg::DIV_BITS-1:0] dvd_in,
  input  wire asmu_pkg::div_side_t        side_in,
  output asmu_pkg::div_side_t             side_out,
  output logic [asmu_pkg::DIV_BITS-1:0]   q_out
);
  import asmu_pkg::*;

  logic [15:0]         rem_r  [DIV_BITS];
  logic [DIV_BITS-1:0] dvd_r  [DIV_BITS];
  logic [15:0]         d_r    [DIV_BITS];
  div_side_t           side_r [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    logic [15:0]         rem_i, d_i, rem_nxt;
    logic [DIV_BITS-1:0] dvd_i, dvd_nxt;
    div_side_t           side_i;
    logic [16:0]         trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign dvd_i  = dvd_in;
      assign d_i    = d_in;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign dvd_i  = dvd_r[k-1];
      assign d_i    = d_r[k-1];
      assign side_i = side_r[k-1];
    end

    always_comb begin
      trial   = {rem_i, dvd_i[DIV_BITS-1]};
      ge      = (trial >= {1'b0, d_i});
      rem_nxt = ge ? 16'(trial - {1'b0, d_i}) : trial[15:0];
      dvd_nxt = {dvd_i[DIV_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        dvd_r[k]  <= dvd_nxt;
        d_r[k]    <= d_i;
        side_r[k] <= side_i;
      end
    end
  end

  assign q_out    = dvd_r[DIV_BITS-1];
  assign side_out = side_r[DIV_BITS-1];
endmodule
`default_nettype wire

// ===== src/asmu_lane.sv =====
// ---------------------------------------------------------------------------
// asmu_lane
// One axis: stability and damping terms, rate/speed divide, scaled moment.
// ---------------------------------------------------------------------------
`default_nettype none
module asmu_lane (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] stab_coef,
  input  wire logic signed [15:0] angle,
  input  wire logic signed [23:0] damp_coef,
  input  wire logic signed [15:0] rate,
  input  wire logic [15:0]        speed,
  input  wire logic [51:0]        qm,
  output asmu_pkg::moment_t       moment
);
  import asmu_pkg::*;

  logic signed [31:0] stab1_r;
  logic signed [39:0] prod1_r;
  logic [15:0]        spd1_r, spd2_r;
  logic [39:0]        mag2_r;
  div_side_t          side2_r, side_q;
  logic [DIV_BITS-1:0] quo;

  logic signed [48:0] damp_d1_r;
  logic signed [31:0] stab_d1_r;
  logic signed [49:0] c_d2_r;
  logic               neg_d3_r, neg_m1_r, neg_m2_r, neg_m3_r, neg_m4_r;
  logic [48:0]        cmag_d3_r;
  logic [50:0]        p00_r, p01_r, p00_m2_r;
  logic [49:0]        p10_r, p11_r, p11_m2_r;
  logic [52:0]        mid_r;
  logic [100:0]       prod_m3_r;
  logic [33:0]        mag_m4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      stab1_r      <= stab_coef * angle;
      prod1_r      <= damp_coef * rate;
      spd1_r       <= speed;
      spd2_r       <= spd1_r;
      side2_r.neg  <= prod1_r[39];
      side2_r.stab <= stab1_r;
      mag2_r       <= prod1_r[39] ? 40'(-prod1_r) : 40'(prod1_r);
    end
  end

  asmu_div u_div (
    .clk      (clk),
    .en       (en),
    .d_in     (spd2_r),
    .dvd_in   ({mag2_r, 8'h00}),
    .side_in  (side2_r),
    .side_out (side_q),
    .q_out    (quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      // damping term back to signed
      damp_d1_r <= side_q.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      stab_d1_r <= side_q.stab;
      c_d2_r    <= -50'(stab_d1_r) - 50'(damp_d1_r);
      neg_d3_r  <= c_d2_r[49];
      cmag_d3_r <= c_d2_r[49] ? 49'(-c_d2_r) : 49'(c_d2_r);
      // |c| * qm as four partial products
      p00_r     <= cmag_d3_r[24:0] * qm[25:0];
      p01_r     <= cmag_d3_r[24:0] * qm[51:26];
      p10_r     <= cmag_d3_r[48:25] * qm[25:0];
      p11_r     <= cmag_d3_r[48:25] * qm[51:26];
      neg_m1_r  <= neg_d3_r;
      mid_r     <= 53'({p01_r, 1'b0}) + 53'(p10_r);
      p00_m2_r  <= p00_r;
      p11_m2_r  <= p11_r;
      neg_m2_r  <= neg_m1_r;
      prod_m3_r <= 101'(p00_m2_r) + (101'(mid_r) << 25) + (101'(p11_m2_r) << 51);
      neg_m3_r  <= neg_m2_r;
      // anything at or above 2^33 saturates the torque sum regardless
      mag_m4_r  <= (|prod_m3_r[100:66]) ? 34'h2_0000_0000 : {1'b0, prod_m3_r[65:33]};
      neg_m4_r  <= neg_m3_r;
    end
  end

  assign moment.neg = neg_m4_r;
  assign moment.mag = mag_m4_r;
endmodule
`default_nettype wire

// ===== src/asmu_merge.sv =====
// ---------------------------------------------------------------------------
// asmu_merge
// Adds the three lane moments to the torques when gated on (else passes them), saturates, holds the result.
// ---------------------------------------------------------------------------
`default_nettype none
module asmu_merge (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire asmu_pkg::common_t cm,
  input  wire asmu_pkg::moment_t m_p,
  input  wire asmu_pkg::moment_t m_y,
  input  wire asmu_pkg::moment_t m_r,
  output logic                   out_vld,
  output asmu_pkg::res_t         res
);
  import asmu_pkg::*;

  logic   vld_r, vld_nxt;
  res_t   res_r, res_nxt;
  logic   sat_p, sat_y, sat_r;
  logic [31:0] sum_p, sum_y, sum_r;

  function automatic logic [32:0] sat_add(logic [31:0] tq, moment_t m);
    logic signed [35:0] mv, s;
    logic               hi, lo;
    mv = m.neg ? -$signed({2'b00, m.mag}) : $signed({2'b00, m.mag});
    s  = 36'($signed(tq)) + mv;
    hi = (s > 36'sh0_7FFF_FFFF);
    lo = (s < -36'sh0_8000_0000);
    if (hi) return {1'b1, 32'h7FFF_FFFF};
    if (lo) return {1'b1, 32'h8000_0000};
    return {1'b0, s[31:0]};
  endfunction

  always_comb begin
    {sat_p, sum_p} = sat_add(cm.tq_p, m_p);
    {sat_y, sum_y} = sat_add(cm.tq_y, m_y);
    {sat_r, sum_r} = sat_add(cm.tq_r, m_r);
    vld_nxt = en ? cm.vld : vld_r;
    res_nxt = res_r;
    if (en) begin
      if (cm.gate) begin
        res_nxt = '{tq_p: sum_p, tq_y: sum_y, tq_r: sum_r, applied: 1'b1,
                    sat: sat_p | sat_y | sat_r};
      end else begin
        res_nxt = '{tq_p: cm.tq_p, tq_y: cm.tq_y, tq_r: cm.tq_r, applied: 1'b0,
                    sat: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_vld = vld_r;
  assign res     = res_r;
endmodule
`default_nettype wire

// ===== src/aero_stability_moment_unit.sv =====
// ---------------------------------------------------------------------------
// aero_stability_moment_unit
// Static stability and rate damping moments added to three torque axes.
// ---------------------------------------------------------------------------
// Usage:
//  - in_ch carries one aircraft state per item (valid/ready); out_ch returns
//    one result per item in order: three saturated torques, moments_applied
//    and saturated.
//  - cfg_we/cfg_idx/cfg_wdata write the eight coefficient registers; write
//    them only while no item is in flight.
//  - Throughput is one item per clock unless out_ch stalls. An accepted item
//    passes the input stage, two product stages, a 48-stage divider for
//    damping*rate/airspeed (one quotient bit per stage), seven stages for the
//    signed combine and moment multiply, and the saturating output register.
//  - Three axis lanes run side by side; the merge stage adds their moments.
//  - Reset clears all valid bits and loads the register defaults.
//  - When out_ch stalls the whole pipeline holds; in_ch.ready drops only
//    while a result sits unaccepted in the output register.
// ---------------------------------------------------------------------------
`default_nettype none
module aero_stability_moment_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  asmu_in_if.sink          in_ch,
  asmu_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [31:0] cfg_wdata
);
  import asmu_pkg::*;

  logic [15:0]        min_air_r;
  logic signed [15:0] stab_p_r, stab_y_r, stab_r_r;
  logic signed [23:0] damp_p_r, damp_y_r, damp_r_r;
  logic [31:0]        mfac_r;

  logic               en, out_vld;
  logic [16:0]        fwd_mag;
  logic               gate;
  logic signed [15:0] aoa_c, slip_c;

  logic               s0_vld_r, s0_gate_r;
  logic signed [15:0] s0_aoa_r, s0_slip_r, s0_rp_r, s0_ry_r, s0_rr_r;
  logic [15:0]        s0_speed_r;
  logic [19:0]        s0_dyn_r;
  logic [31:0]        s0_tp_r, s0_ty_r, s0_tr_r;

  common_t            cm_r [LANE_LAT];
  moment_t            m_p, m_y, m_r;
  res_t               res;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_air_r <= 16'd64;
      stab_p_r  <= '0;
      stab_y_r  <= '0;
      stab_r_r  <= '0;
      damp_p_r  <= '0;
      damp_y_r  <= '0;
      damp_r_r  <= '0;
      mfac_r    <= 32'h0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_MIN_AIRSPEED:  min_air_r <= cfg_wdata[15:0];
        CFG_PITCH_STAB:    stab_p_r  <= cfg_wdata[15:0];
        CFG_YAW_STAB:      stab_y_r  <= cfg_wdata[15:0];
        CFG_ROLL_STAB:     stab_r_r  <= cfg_wdata[15:0];
        CFG_PITCH_DAMP:    damp_p_r  <= cfg_wdata[23:0];
        CFG_YAW_DAMP:      damp_y_r  <= cfg_wdata[23:0];
        CFG_ROLL_DAMP:     damp_r_r  <= cfg_wdata[23:0];
        CFG_MOMENT_FACTOR: mfac_r    <= cfg_wdata;
        default:           mfac_r    <= mfac_r;
      endcase
    end
  end

  assign en          = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    fwd_mag = in_ch.forward_speed[16] ? 17'(-in_ch.forward_speed)
                                      : 17'(in_ch.forward_speed);
    gate    = !((in_ch.air_speed < min_air_r) || (fwd_mag < {1'b0, min_air_r}));
    aoa_c   = in_ch.attack_angle;
    if (in_ch.attack_angle > 16'(ANGLE_LIMIT))  aoa_c = 16'(ANGLE_LIMIT);
    if (in_ch.attack_angle < -16'(ANGLE_LIMIT)) aoa_c = -16'(ANGLE_LIMIT);
    slip_c  = in_ch.slip_angle;
    if (in_ch.slip_angle > 16'(ANGLE_LIMIT))    slip_c = 16'(ANGLE_LIMIT);
    if (in_ch.slip_angle < -16'(ANGLE_LIMIT))   slip_c = -16'(ANGLE_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_gate_r  <= gate;
      s0_aoa_r   <= aoa_c;
      s0_slip_r  <= slip_c;
      s0_rp_r    <= in_ch.rate_pitch;
      s0_ry_r    <= in_ch.rate_yaw;
      s0_rr_r    <= in_ch.rate_roll;
      s0_speed_r <= (in_ch.air_speed == 16'd0) ? 16'd1 : in_ch.air_speed;
      s0_dyn_r   <= in_ch.dyn_pressure;
      s0_tp_r    <= in_ch.torque_in_pitch;
      s0_ty_r    <= in_ch.torque_in_yaw;
      s0_tr_r    <= in_ch.torque_in_roll;
    end
  end

  // common delay line, aligned stage for stage with the lanes
  for (genvar k = 0; k < LANE_LAT; k++) begin : g_cm
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cm_r[0].vld <= 1'b0;
        end else if (en) begin
          cm_r[0].vld <= s0_vld_r;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          cm_r[0].gate <= s0_gate_r;
          cm_r[0].tq_p <= s0_tp_r;
          cm_r[0].tq_y <= s0_ty_r;
          cm_r[0].tq_r <= s0_tr_r;
          cm_r[0].qm   <= s0_dyn_r * mfac_r;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cm_r[k].vld <= 1'b0;
        end else if (en) begin
          cm_r[k].vld <= cm_r[k-1].vld;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          cm_r[k].gate <= cm_r[k-1].gate;
          cm_r[k].tq_p <= cm_r[k-1].tq_p;
          cm_r[k].tq_y <= cm_r[k-1].tq_y;
          cm_r[k].tq_r <= cm_r[k-1].tq_r;
          cm_r[k].qm   <= cm_r[k-1].qm;
        end
      end
    end
  end

  asmu_lane u_lane_p (
    .clk (clk), .en (en), .stab_coef (stab_p_r), .angle (s0_aoa_r),
    .damp_coef (damp_p_r), .rate (s0_rp_r), .speed (s0_speed_r),
    .qm (cm_r[QM_TAP].qm), .moment (m_p)
  );

  asmu_lane u_lane_y (
    .clk (clk), .en (en), .stab_coef (stab_y_r), .angle (s0_slip_r),
    .damp_coef (damp_y_r), .rate (s0_ry_r), .speed (s0_speed_r),
    .qm (cm_r[QM_TAP].qm), .moment (m_y)
  );

  asmu_lane u_lane_r (
    .clk (clk), .en (en), .stab_coef (stab_r_r), .angle (s0_slip_r),
    .damp_coef (damp_r_r), .rate (s0_rr_r), .speed (s0_speed_r),
    .qm (cm_r[QM_TAP].qm), .moment (m_r)
  );

  asmu_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cm      (cm_r[LANE_LAT-1]),
    .m_p     (m_p),
    .m_y     (m_y),
    .m_r     (m_r),
    .out_vld (out_vld),
    .res     (res)
  );

  assign out_ch.valid            = out_vld;
  assign out_ch.torque_out_pitch = res.tq_p;
  assign out_ch.torque_out_yaw   = res.tq_y;
  assign out_ch.torque_out_roll  = res.tq_r;
  assign out_ch.moments_applied  = res.applied;
  assign out_ch.saturated        = res.sat;

`include "aero_stability_moment_unit_assert.svh"

  // a gated-off item never reports clipping
  `ASMU_ASSERT_NOW(a_pass_no_sat, out_vld && !res.applied, !res.sat)
  // a held result blocks new input
  `ASMU_ASSERT_NOW(a_stall_blocks_in, out_vld && !out_ch.ready, !in_ch.ready)
  // the last pipeline stage lands in the output register
  `ASMU_ASSERT_NEXT(a_tail_to_out, en && cm_r[LANE_LAT-1].vld, out_vld)

endmodule
`default_nettype wire
